FILE: hw/rtl/fractional_n_pll_tuning_word_defines.svh
// Assertion macros used by the checker file.
`ifndef FRACTIONAL_N_PLL_TUNING_WORD_DEFINES_SVH
`define FRACTIONAL_N_PLL_TUNING_WORD_DEFINES_SVH

// A plain clocked property, disabled while reset is high.
`define FNPTW_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An overlapping implication, disabled while reset is high.
`define FNPTW_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/fnptw_pkg.sv
package fnptw_pkg;

   localparam int FRAC_BITS_DEF = 19;
   localparam int CFG_W         = 25;
   localparam int CARRIER_W     = 32;
   localparam int F_W           = 30;   // clamped carrier stays below 2^30
   localparam int PFD_W         = 25;
   localparam int COEF_W        = 15;   // divider times 1300
   localparam int QI_W          = F_W;  // full integer quotient, one bit per carrier bit
   localparam int DQ_W          = 10;   // deviation quotient bits before saturation
   localparam int PREP_STAGES   = 4;

   localparam logic [CARRIER_W-1:0] CARRIER_MIN     = 32'd119000000;
   localparam logic [CARRIER_W-1:0] CARRIER_MAX     = 32'd1050000000;
   localparam logic [CARRIER_W-1:0] CARRIER_DEFAULT = 32'd145300000;
   localparam logic [CARRIER_W-1:0] THR_BAND1       = 32'd705000000;
   localparam logic [CARRIER_W-1:0] THR_BAND2       = 32'd525000000;
   localparam logic [CARRIER_W-1:0] THR_BAND3       = 32'd353000000;
   localparam logic [CARRIER_W-1:0] THR_BAND4       = 32'd239000000;
   localparam logic [CARRIER_W-1:0] THR_BAND5       = 32'd177000000;

   localparam logic [3:0] SYNTH_SELECT = 4'd8;
   localparam logic [31:0] THIRD_MAGIC = 32'hAAAAAAAB;   // floor(x/3) = x*M >> 33

   localparam logic [0:0] CSR_REF_OSC = 1'b0;
   localparam logic [0:0] CSR_NOM_OSC = 1'b1;

   localparam logic [4:0] DIV_4  = 5'd4;
   localparam logic [4:0] DIV_6  = 5'd6;
   localparam logic [4:0] DIV_8  = 5'd8;
   localparam logic [4:0] DIV_12 = 5'd12;
   localparam logic [4:0] DIV_16 = 5'd16;
   localparam logic [4:0] DIV_24 = 5'd24;

   // Output divider times the 1300 Hz deviation.
   function automatic logic [COEF_W-1:0] dev_coef(input logic [4:0] div);
      logic [COEF_W-1:0] c;
      case (div)
         DIV_4:   c = 15'd5200;
         DIV_6:   c = 15'd7800;
         DIV_8:   c = 15'd10400;
         DIV_12:  c = 15'd15600;
         DIV_16:  c = 15'd20800;
         DIV_24:  c = 15'd31200;
         default: c = 15'd0;
      endcase
      return c;
   endfunction

endpackage

FILE: hw/rtl/fractional_n_pll_tuning_word.sv
// Fractional-N tuning word calculator. Pulse start with a carrier frequency in Hz
// on req_carrier_hz and the block answers with exactly one result, marked by
// rsp_valid for one cycle. The result cannot be held off, so the receiver must
// take it in that cycle. A new request is taken in every cycle: the work runs
// through a fixed pipeline of one stage per quotient bit, so the rate is one
// request per clock; the pipeline holds the thirty integer quotient steps (one
// per bit of the clamped carrier, so the remainder is exact even for a tiny
// reference) plus the FRAC_BITS fraction steps. Busy is high only during reset.
// A carrier outside 119 MHz to 1050 MHz is replaced by 145.3 MHz. The oscillator
// registers are written through the csr port and must only change while no
// request is in flight.
module fractional_n_pll_tuning_word
   import fnptw_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [CARRIER_W-1:0] req_carrier_hz,
   output logic                 rsp_valid,
   output logic [3:0]           rsp_band_setting,
   output logic [4:0]           rsp_output_divider,
   output logic [7:0]           rsp_integer_part,
   output logic [19:0]          rsp_fraction_word,
   output logic [9:0]           rsp_deviation_word,
   input  logic                 csr_we,
   input  logic [0:0]           csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int NS   = QI_W + FRAC_BITS;            // division stages
   localparam int RQW  = PFD_W + QI_W;                // remainder width
   localparam int DVW  = (COEF_W + FRAC_BITS > CFG_W + DQ_W) ?
                         COEF_W + FRAC_BITS : CFG_W + DQ_W;
   localparam int FSW  = FRAC_BITS + 21;

   logic [CFG_W-1:0] ref_ff, nom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= CFG_W'(26000000);
         nom_ff <= CFG_W'(26000000);
      end else if (csr_we) begin
         if (csr_index == CSR_REF_OSC) begin
            ref_ff <= csr_wdata;
         end else begin
            nom_ff <= csr_wdata;
         end
      end
   end

   assign busy = reset;

   // Stage 1: clamp the carrier, pick the band and prepare the pfd numerator.
   logic [CARRIER_W-1:0] f_cl;
   logic [2:0]           band_in;
   logic [4:0]           div_in;
   logic [CFG_W-1:0]     x_in;
   logic                 three_in;

   always_comb begin
      f_cl = req_carrier_hz;
      if (req_carrier_hz < CARRIER_MIN || req_carrier_hz > CARRIER_MAX) begin
         f_cl = CARRIER_DEFAULT;
      end
      if (f_cl < THR_BAND5) begin
         band_in = 3'd5; div_in = DIV_24; x_in = ref_ff >> 2; three_in = 1'b1;
      end else if (f_cl < THR_BAND4) begin
         band_in = 3'd4; div_in = DIV_16; x_in = ref_ff >> 3; three_in = 1'b0;
      end else if (f_cl < THR_BAND3) begin
         band_in = 3'd3; div_in = DIV_12; x_in = ref_ff >> 1; three_in = 1'b1;
      end else if (f_cl < THR_BAND2) begin
         band_in = 3'd2; div_in = DIV_8;  x_in = ref_ff >> 2; three_in = 1'b0;
      end else if (f_cl < THR_BAND1) begin
         band_in = 3'd1; div_in = DIV_6;  x_in = ref_ff;      three_in = 1'b1;
      end else begin
         band_in = 3'd0; div_in = DIV_4;  x_in = ref_ff >> 1; three_in = 1'b0;
      end
   end

   logic                 p1_vld_ff, p2_vld_ff, p3_vld_ff;
   logic [F_W-1:0]       p1_f_ff, p2_f_ff, p3_f_ff;
   logic [2:0]           p1_band_ff, p2_band_ff, p3_band_ff;
   logic [4:0]           p1_div_ff, p2_div_ff, p3_div_ff;
   logic [CFG_W-1:0]     p1_x_ff, p2_x_ff;
   logic                 p1_three_ff, p2_three_ff;
   logic [CFG_W+31:0]    p2_prod_ff;
   logic [PFD_W-1:0]     p3_pfd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= start;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_f_ff     <= f_cl[F_W-1:0];
      p1_band_ff  <= band_in;
      p1_div_ff   <= div_in;
      p1_x_ff     <= x_in;
      p1_three_ff <= three_in;
      // Stage 2: reciprocal multiply for the divide by three.
      p2_f_ff     <= p1_f_ff;
      p2_band_ff  <= p1_band_ff;
      p2_div_ff   <= p1_div_ff;
      p2_x_ff     <= p1_x_ff;
      p2_three_ff <= p1_three_ff;
      p2_prod_ff  <= (CFG_W + 32)'(p1_x_ff) * (CFG_W + 32)'(THIRD_MAGIC);
      // Stage 3: phase detector frequency.
      p3_f_ff     <= p2_f_ff;
      p3_band_ff  <= p2_band_ff;
      p3_div_ff   <= p2_div_ff;
      p3_pfd_ff   <= p2_three_ff ? PFD_W'(p2_prod_ff[CFG_W+31:33]) : p2_x_ff;
   end

   // Division pipeline. Index 0 holds the overflow checks; stages 1..QI_W resolve
   // the integer quotient, the following FRAC_BITS stages the fraction. The
   // deviation division runs in stages 1..10 alongside.
   logic                 st_vld_ff  [0:NS];
   logic [RQW-1:0]       st_rem_ff  [0:NS];
   logic [QI_W-1:0]      st_qi_ff   [0:NS];
   logic [FRAC_BITS-1:0] st_qf_ff   [0:NS];
   logic [DVW-1:0]       st_dr_ff   [0:NS];
   logic [DQ_W-1:0]      st_dq_ff   [0:NS];
   logic [PFD_W-1:0]     st_pfd_ff  [0:NS];
   logic [2:0]           st_band_ff [0:NS];
   logic [4:0]           st_div_ff  [0:NS];
   logic                 st_qovf_ff [0:NS];
   logic                 st_dovf_ff [0:NS];

   logic [DVW-1:0] dnum;
   assign dnum = DVW'(dev_coef(p3_div_ff)) << FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_vld_ff[0] <= 1'b0;
      end else begin
         st_vld_ff[0] <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      st_rem_ff[0]  <= RQW'(p3_f_ff);
      st_qi_ff[0]   <= '0;
      st_qf_ff[0]   <= '0;
      st_dr_ff[0]   <= dnum;
      st_dq_ff[0]   <= '0;
      st_pfd_ff[0]  <= p3_pfd_ff;
      st_band_ff[0] <= p3_band_ff;
      st_div_ff[0]  <= p3_div_ff;
      // A zero pfd is flagged here; the integer part then saturates.
      st_qovf_ff[0] <= PFD_W'(p3_f_ff >> QI_W) >= p3_pfd_ff;
      // Deviation of 1024 or more saturates; a zero nominal lands here as well.
      st_dovf_ff[0] <= dnum >= (DVW'(nom_ff) << DQ_W);
   end

   for (genvar k = 1; k <= NS; k++) begin : g_div
      localparam int QI_BIT = (k <= QI_W) ? QI_W - k : 0;
      localparam int QF_BIT = (k > QI_W) ? FRAC_BITS + QI_W - k : 0;
      localparam int DQ_BIT = (k <= DQ_W) ? DQ_W - k : 0;

      logic [RQW-1:0]       rem_in;
      logic [QI_W-1:0]      qi_in;
      logic [FRAC_BITS-1:0] qf_in;
      logic [DVW-1:0]       dr_in;
      logic [DQ_W-1:0]      dq_in;

      always_comb begin
         logic [RQW-1:0] sub;
         logic [RQW-1:0] r2;
         logic [DVW-1:0] dsub;
         rem_in = st_rem_ff[k-1];
         qi_in  = st_qi_ff[k-1];
         qf_in  = st_qf_ff[k-1];
         dr_in  = st_dr_ff[k-1];
         dq_in  = st_dq_ff[k-1];
         sub    = '0;
         r2     = '0;
         dsub   = '0;
         if (k <= QI_W) begin
            sub = RQW'(st_pfd_ff[k-1]) << QI_BIT;
            if (st_rem_ff[k-1] >= sub) begin
               rem_in = st_rem_ff[k-1] - sub;
               qi_in[QI_BIT] = 1'b1;
            end
         end else begin
            r2 = st_rem_ff[k-1] << 1;
            rem_in = r2;
            if (r2 >= RQW'(st_pfd_ff[k-1])) begin
               rem_in = r2 - RQW'(st_pfd_ff[k-1]);
               qf_in[QF_BIT] = 1'b1;
            end
         end
         if (k <= DQ_W) begin
            dsub = DVW'(nom_ff) << DQ_BIT;
            if (st_dr_ff[k-1] >= dsub) begin
               dr_in = st_dr_ff[k-1] - dsub;
               dq_in[DQ_BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_vld_ff[k] <= 1'b0;
         end else begin
            st_vld_ff[k] <= st_vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         st_rem_ff[k]  <= rem_in;
         st_qi_ff[k]   <= qi_in;
         st_qf_ff[k]   <= qf_in;
         st_dr_ff[k]   <= dr_in;
         st_dq_ff[k]   <= dq_in;
         st_pfd_ff[k]  <= st_pfd_ff[k-1];
         st_band_ff[k] <= st_band_ff[k-1];
         st_div_ff[k]  <= st_div_ff[k-1];
         st_qovf_ff[k] <= st_qovf_ff[k-1];
         st_dovf_ff[k] <= st_dovf_ff[k-1];
      end
   end

   // Output stage: saturate and assemble the words.
   logic [7:0]     n_in;
   logic [19:0]    frac_in;
   logic [9:0]     dev_in;
   logic [FSW-1:0] fsum;

   always_comb begin
      if (st_qovf_ff[NS] || st_qi_ff[NS] > QI_W'(256)) begin
         n_in = 8'd255;
      end else if (st_qi_ff[NS] == '0) begin
         n_in = 8'd0;
      end else begin
         n_in = 8'(st_qi_ff[NS] - QI_W'(1));
      end
      if (st_pfd_ff[NS] == '0) begin
         fsum = FSW'(1) << FRAC_BITS;
      end else begin
         fsum = (FSW'(1) << FRAC_BITS) + FSW'(st_qf_ff[NS]);
      end
      frac_in = fsum[19:0];
      dev_in  = st_dovf_ff[NS] ? 10'd1023 : st_dq_ff[NS];
   end

   logic        rsp_vld_ff;
   logic [3:0]  band_ff;
   logic [4:0]  div_ff;
   logic [7:0]  n_ff;
   logic [19:0] frac_ff;
   logic [9:0]  dev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= st_vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      band_ff <= {1'b0, st_band_ff[NS]} + SYNTH_SELECT;
      div_ff  <= st_div_ff[NS];
      n_ff    <= n_in;
      frac_ff <= frac_in;
      dev_ff  <= dev_in;
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_band_setting   = band_ff;
   assign rsp_output_divider = div_ff;
   assign rsp_integer_part   = n_ff;
   assign rsp_fraction_word  = frac_ff;
   assign rsp_deviation_word = dev_ff;

endmodule

FILE: hw/rtl/fnptw_checker.sv
`include "fractional_n_pll_tuning_word_defines.svh"

module fnptw_checker
   import fnptw_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic [CARRIER_W-1:0] req_carrier_hz,
   input logic                 rsp_valid,
   input logic [3:0]           rsp_band_setting,
   input logic [4:0]           rsp_output_divider,
   input logic [7:0]           rsp_integer_part,
   input logic [19:0]          rsp_fraction_word,
   input logic [9:0]           rsp_deviation_word,
   input logic                 csr_we,
   input logic [0:0]           csr_index,
   input logic [CFG_W-1:0]     csr_wdata
);

   localparam int LATENCY = PREP_STAGES + QI_W + FRAC_BITS + 1;

   // Every result answers an earlier request that was taken while not busy.
   `FNPTW_ASSERT_IMP(a_rsp_latency, rsp_valid, $past(start && !busy, LATENCY),
      "result without a matching request")

   // The band code and the output divider must come from the same band.
   `FNPTW_ASSERT_IMP(a_band_div, rsp_valid,
      (rsp_output_divider == DIV_4  && rsp_band_setting == 4'd8)  ||
      (rsp_output_divider == DIV_6  && rsp_band_setting == 4'd9)  ||
      (rsp_output_divider == DIV_8  && rsp_band_setting == 4'd10) ||
      (rsp_output_divider == DIV_12 && rsp_band_setting == 4'd11) ||
      (rsp_output_divider == DIV_16 && rsp_band_setting == 4'd12) ||
      (rsp_output_divider == DIV_24 && rsp_band_setting == 4'd13),
      "band code does not match output divider")

   // Busy is low outside reset; no request can be taken while the block is in reset.
   `FNPTW_ASSERT(a_busy_reset, !busy, "busy high outside reset")

endmodule

bind fractional_n_pll_tuning_word fnptw_checker #(.FRAC_BITS(FRAC_BITS)) u_fnptw_checker (.*);

FILE: test/fractional_n_pll_tuning_word_tb.sv
`timescale 1ns / 1ps

module fractional_n_pll_tuning_word_tb;
   import fnptw_pkg::*;

   // One tuning result as the block presents it.
   typedef struct packed {
      logic [3:0]  band;
      logic [4:0]  divider;
      logic [7:0]  n_int;
      logic [19:0] frac;
      logic [9:0]  dev;
   } tuning_type;

   localparam int LATENCY    = 4 + QI_W + FRAC_BITS_DEF;
   localparam int CYCLE_STOP = 1500000;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [CARRIER_W-1:0] req_carrier_hz;
   logic                 rsp_valid;
   logic [3:0]           rsp_band_setting;
   logic [4:0]           rsp_output_divider;
   logic [7:0]           rsp_integer_part;
   logic [19:0]          rsp_fraction_word;
   logic [9:0]           rsp_deviation_word;
   logic                 csr_we;
   logic [0:0]           csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   fractional_n_pll_tuning_word dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_carrier_hz(req_carrier_hz), .rsp_valid(rsp_valid),
      .rsp_band_setting(rsp_band_setting), .rsp_output_divider(rsp_output_divider),
      .rsp_integer_part(rsp_integer_part), .rsp_fraction_word(rsp_fraction_word),
      .rsp_deviation_word(rsp_deviation_word), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Our own copy of the oscillator registers, updated when the driver writes them.
   logic [CFG_W-1:0] ref_osc_model;
   logic [CFG_W-1:0] nom_osc_model;

   // Carriers waiting to be sent; a marker entry stands for a register write or a drain.
   typedef struct {
      bit               is_csr;
      bit               drain;     // pause until every expected tuning result is back
      logic [0:0]       idx;
      logic [CFG_W-1:0] val;
      logic [31:0]      carrier;
   } pending_type;

   pending_type pending_q[$];
   tuning_type  tuning_expect_q[$];
   int          mismatches;
   int          cycles;
   bit          stimulus_done;

   // Computes the tuning word for one carrier with exact integer arithmetic.
   function automatic tuning_type compute_tuning(logic [31:0] carrier,
                                                 logic [CFG_W-1:0] ref_hz,
                                                 logic [CFG_W-1:0] nom_hz);
      tuning_type  r;
      logic [63:0] f, pfd, q, rem, fr, dv, one;
      logic [3:0]  band;
      logic [4:0]  div;
      one = 64'd1 << FRAC_BITS_DEF;
      f = {32'd0, carrier};
      if (f < CARRIER_MIN || f > CARRIER_MAX) f = CARRIER_DEFAULT;
      band = 4'd0;
      div  = DIV_4;
      if (f < THR_BAND1) begin band = 4'd1; div = DIV_6;  end
      if (f < THR_BAND2) begin band = 4'd2; div = DIV_8;  end
      if (f < THR_BAND3) begin band = 4'd3; div = DIV_12; end
      if (f < THR_BAND4) begin band = 4'd4; div = DIV_16; end
      if (f < THR_BAND5) begin band = 4'd5; div = DIV_24; end
      pfd = (64'd2 * ref_hz) / div;
      if (pfd == 0) begin
         r.n_int = 8'd255;
         fr = one;
      end else begin
         q   = f / pfd;
         rem = f - q * pfd;
         if (q == 0) r.n_int = 8'd0;
         else if (q - 1 > 255) r.n_int = 8'd255;
         else r.n_int = q[7:0] - 8'd1;
         fr = one + (rem << FRAC_BITS_DEF) / pfd;
      end
      if (nom_hz == 0) begin
         dv = 64'd1023;
      end else begin
         dv = (one * div * 64'd1300) / nom_hz;
         if (dv > 1023) dv = 1023;
      end
      r.band    = band + SYNTH_SELECT;
      r.divider = div;
      r.frac    = fr[19:0];
      r.dev     = dv[9:0];
      return r;
   endfunction

   // Idle cycles before the next request; zero is favored so requests run back to back.
   function automatic int next_gap();
      return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 19));
   endfunction

   // Driver: sends requests with random gaps and performs register writes when idle.
   int  gap_left;
   int  settle_left;
   bit  gap_drawn;
   always @(posedge clock) begin
      logic start_nx;
      logic we_nx;
      start_nx = 1'b0;
      we_nx    = 1'b0;
      if (reset) begin
         start       <= 1'b0;
         csr_we      <= 1'b0;
         gap_drawn   <= 1'b0;
         settle_left <= 0;
      end else begin
         if (start && !busy)
            tuning_expect_q.push_back(compute_tuning(req_carrier_hz, ref_osc_model,
                                                     nom_osc_model));
         if (csr_we) begin
            if (csr_index == CSR_REF_OSC) ref_osc_model <= csr_wdata;
            else nom_osc_model <= csr_wdata;
         end
         if (pending_q.size() == 0) begin
            stimulus_done <= 1'b1;
         end else if (pending_q[0].is_csr || pending_q[0].drain) begin
            // Wait for every result, then a settle time, before touching the registers.
            if (tuning_expect_q.size() != 0 || (start && !busy)) begin
               settle_left <= LATENCY + 4;
            end else if (settle_left > 0) begin
               settle_left <= settle_left - 1;
            end else begin
               if (pending_q[0].is_csr) begin
                  we_nx      = 1'b1;
                  csr_index <= pending_q[0].idx;
                  csr_wdata <= pending_q[0].val;
               end
               void'(pending_q.pop_front());
            end
         end else if (!gap_drawn) begin
            gap_left  <= next_gap();
            gap_drawn <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (!busy) begin
            start_nx        = 1'b1;
            req_carrier_hz <= pending_q[0].carrier;
            void'(pending_q.pop_front());
            gap_left       <= next_gap();
         end
         start  <= start_nx;
         csr_we <= we_nx;
      end
   end

   // Monitor: every strobe must match the oldest expectation.
   always @(posedge clock) begin
      tuning_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_band_setting, rsp_output_divider, rsp_integer_part,
                 rsp_fraction_word, rsp_deviation_word};
         if (tuning_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected tuning result %h", got);
         end else begin
            want = tuning_expect_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"tuning mismatch: band %0d/%0d div %0d/%0d n %0d/%0d",
                            " frac %h/%h dev %0d/%0d"},
                           want.band, got.band, want.divider, got.divider, want.n_int,
                           got.n_int, want.frac, got.frac, want.dev, got.dev);
            end
         end
      end
   end

   task automatic add_carrier(logic [31:0] c);
      pending_type p;
      p = '{0, 0, 1'b0, '0, c};
      pending_q.push_back(p);
   endtask

   task automatic add_write(logic [0:0] idx, logic [CFG_W-1:0] v);
      pending_type p;
      p = '{1, 0, idx, v, 32'd0};
      pending_q.push_back(p);
   endtask

   // A carrier mostly in the legal range and near band edges, sometimes anything.
   function automatic logic [31:0] random_carrier();
      logic [31:0] edges[7];
      int          k;
      edges = '{CARRIER_MIN, THR_BAND5, THR_BAND4, THR_BAND3, THR_BAND2, THR_BAND1,
                 CARRIER_MAX};
      k = $urandom_range(0, 9);
      if (k < 6) return $urandom_range(CARRIER_MIN, CARRIER_MAX);
      if (k < 8) return edges[$urandom_range(0, 6)] + $urandom_range(0, 4) - 2;
      return $urandom;
   endfunction

   initial begin
      logic [CFG_W-1:0] settings[6][2];
      int               ph;
      reset          = 1'b1;
      start          = 1'b0;
      req_carrier_hz = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_REF_OSC;
      csr_wdata      = '0;
      mismatches     = 0;
      cycles         = 0;
      stimulus_done  = 1'b0;
      ref_osc_model  = 25'd26000000;
      nom_osc_model  = 25'd26000000;

      // Directed: range and band edges on both sides, default, ones/zeros, 0x55/0x2A.
      add_carrier(32'd0);
      add_carrier(32'hFFFFFFFF);
      add_carrier(CARRIER_MIN - 1);
      add_carrier(CARRIER_MIN);
      add_carrier(CARRIER_MAX);
      add_carrier(CARRIER_MAX + 1);
      add_carrier(THR_BAND5 - 1);
      add_carrier(THR_BAND5);
      add_carrier(THR_BAND4 - 1);
      add_carrier(THR_BAND4);
      add_carrier(THR_BAND3 - 1);
      add_carrier(THR_BAND3);
      add_carrier(THR_BAND2 - 1);
      add_carrier(THR_BAND2);
      add_carrier(THR_BAND1 - 1);
      add_carrier(THR_BAND1);
      add_carrier(CARRIER_DEFAULT);
      add_carrier(32'h55555555);
      add_carrier(32'h2AAAAAAA);

      // Register settings: nominal extremes, zero oscillators (pfd of zero and a forced
      // deviation word), tiny values saturating the integer part, all-ones, defaults.
      settings = '{'{25'd25000000, 25'd32000000}, '{25'd32000000, 25'd25000000},
                   '{25'd0, 25'd0}, '{25'd3, 25'd1}, '{25'h1FFFFFF, 25'h1FFFFFF},
                   '{25'd26000000, 25'd26000000}};
      for (ph = 0; ph < 6; ph++) begin
         add_write(CSR_REF_OSC, settings[ph][0]);
         add_write(CSR_NOM_OSC, settings[ph][1]);
         repeat (15) add_carrier(random_carrier());
      end
      // Random phases at random legal registers, each with a full drain partway through.
      for (ph = 0; ph < 4; ph++) begin
         add_write(CSR_REF_OSC, CFG_W'($urandom_range(25000000, 32000000)));
         add_write(CSR_NOM_OSC, CFG_W'($urandom_range(25000000, 32000000)));
         repeat (150) add_carrier(random_carrier());
         pending_q.push_back('{0, 1, 1'b0, '0, 32'd0});
         repeat (150) add_carrier(random_carrier());
      end
      add_write(CSR_REF_OSC, CFG_W'($urandom));
      add_write(CSR_NOM_OSC, CFG_W'($urandom));
      repeat (100) add_carrier(random_carrier());

      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // End of run: wait for the queue to empty and then stay quiet.
   initial begin
      int quiet;
      quiet = 0;
      while (!(stimulus_done && tuning_expect_q.size() == 0 && quiet > 2 * LATENCY)) begin
         @(posedge clock);
         cycles++;
         if (stimulus_done && tuning_expect_q.size() == 0) quiet++;
         else quiet = 0;
         if (cycles > CYCLE_STOP) break;
      end
      if (cycles > CYCLE_STOP) begin
         $display("fractional_n_pll_tuning_word_tb: done, errors");
      end else if (mismatches == 0) begin
         $display("fractional_n_pll_tuning_word_tb: done, clean");
      end else begin
         $display("fractional_n_pll_tuning_word_tb: done, errors");
      end
      $finish;
   end

endmodule
